@@ rtl/ray_box_intersect_core_macros.svh @@
// Assertion macros used by the checker file of the ray box core.
`ifndef RAY_BOX_INTERSECT_CORE_MACROS_SVH
`define RAY_BOX_INTERSECT_CORE_MACROS_SVH

// Checked at every rising edge, switched off while reset is held.
`define RBI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define RBI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rbi_pkg.sv @@
// ----------------------------------------------------------------------------
// Ray box intersection package
// Widths, word types and register indexes of the ray box core.
// ----------------------------------------------------------------------------
package rbi_pkg;

	localparam int CW  = 32;            // coordinate width
	localparam int FB  = 16;            // fraction bits
	localparam int SW  = 16;            // slack width
	localparam int GW  = CW + 1;        // grown bounds and differences
	localparam int NW  = GW + FB;       // dividend and quotient width
	localparam int DW  = CW;            // divisor magnitude width
	localparam int QLW = 25;            // low part of the quotient per product
	localparam int QHW = NW - QLW;      // high part of the quotient
	localparam int PW  = DW + NW + 1;   // full product width
	localparam int HW  = GW + 1;        // clamped hit coordinate width
	localparam int IW  = 3;             // register index width

	typedef logic signed [CW-1:0] coord_t;

	typedef enum logic [IW-1:0] {
		CFG_LO_X  = 3'd0,
		CFG_LO_Y  = 3'd1,
		CFG_LO_Z  = 3'd2,
		CFG_HI_X  = 3'd3,
		CFG_HI_Y  = 3'd4,
		CFG_HI_Z  = 3'd5,
		CFG_SLACK = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		coord_t view_x;
		coord_t view_y;
		coord_t view_z;
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t dir_x;
		coord_t dir_y;
		coord_t dir_z;
	} ray_word_t;

	typedef struct packed {
		logic   hit;
		coord_t hit_x;
		coord_t hit_y;
		coord_t hit_z;
	} res_word_t;

endpackage

@@ rtl/rbi_ray_if.sv @@
// ----------------------------------------------------------------------------
// Ray channel
// Valid and ready handshake carrying one ray word.
// ----------------------------------------------------------------------------
interface rbi_ray_if;
	logic               valid;
	logic               ready;
	rbi_pkg::ray_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/rbi_res_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid and ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface rbi_res_if;
	logic               valid;
	logic               ready;
	rbi_pkg::res_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ray_box_intersect_core.sv @@
// Throughput: one ray per cycle; a stall on the result side holds every stage.
// The depth is set by the three restoring dividers, one quotient bit per stage.
// Reset clears all valid bits and loads the box 0..1.0 with slack 7.
// ----------------------------------------------------------------------------
// Ray box intersection core
// Slab test of a ray against a grown axis-aligned box, fully pipelined.
// ----------------------------------------------------------------------------
module ray_box_intersect_core (
	input  logic                    clk,
	input  logic                    arst_n,
	rbi_ray_if.sink                 ray,
	rbi_res_if.source               res,
	input  logic                    cfg_we,
	input  logic [rbi_pkg::IW-1:0]  cfg_idx,
	input  logic [rbi_pkg::CW-1:0]  cfg_wdata
);
	import rbi_pkg::*;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [NW-1:0] num;
		logic [NW-1:0] quo;
		logic [DW-1:0] den;
	} div_t;

	typedef struct packed {
		coord_t [2:0]               org;
		coord_t [2:0]               dir;
		logic signed [2:0][GW-1:0]  glo;
		logic signed [2:0][GW-1:0]  ghi;
		logic [2:0]                 in_box;
		logic [2:0]                 neg;
		logic [2:0]                 dnz;
	} ctx_t;

	localparam logic signed [PW-1:0] HMAX = {{(PW-HW+1){1'b0}}, {(HW-1){1'b1}}};
	localparam logic signed [PW-1:0] HMIN = {{(PW-HW+1){1'b1}}, {(HW-1){1'b0}}};
	localparam logic signed [HW-1:0] CMAX = {{(HW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [HW-1:0] CMIN = {{(HW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	function automatic div_t div_step(div_t a);
		logic [DW:0] tr;
		div_t        r;
		tr = {a.rem, a.num[NW-1]};
		r = a;
		r.num = {a.num[NW-2:0], 1'b0};
		if (tr >= {1'b0, a.den}) begin
			r.rem = DW'(tr - {1'b0, a.den});
			r.quo = {a.quo[NW-2:0], 1'b1};
		end else begin
			r.rem = tr[DW-1:0];
			r.quo = {a.quo[NW-2:0], 1'b0};
		end
		return r;
	endfunction

	coord_t          box_lo_q [3];
	coord_t          box_hi_q [3];
	logic [SW-1:0]   slack_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				box_lo_q[k] <= '0;
				box_hi_q[k] <= CW'(1) <<< FB;
			end
			slack_q <= SW'(7);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_LO_X:  box_lo_q[0] <= cfg_wdata;
				CFG_LO_Y:  box_lo_q[1] <= cfg_wdata;
				CFG_LO_Z:  box_lo_q[2] <= cfg_wdata;
				CFG_HI_X:  box_hi_q[0] <= cfg_wdata;
				CFG_HI_Y:  box_hi_q[1] <= cfg_wdata;
				CFG_HI_Z:  box_hi_q[2] <= cfg_wdata;
				CFG_SLACK: slack_q <= cfg_wdata[SW-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic res_vld_q;
	assign en = !res_vld_q || res.ready;
	assign ray.ready = en;

	// Front stage: plane choice, inside flags, grown slabs and divider set-up.
	ctx_t ctx_in;
	div_t div_in [3];
	coord_t eye [3];
	coord_t org [3];
	coord_t dir [3];

	always_comb begin
		logic signed [GW-1:0] dlo, dhi, lo, hi, pl, diff, sl;
		logic [GW-1:0] alo, ahi, mag;
		eye[0] = ray.data.view_x;   eye[1] = ray.data.view_y;   eye[2] = ray.data.view_z;
		org[0] = ray.data.origin_x; org[1] = ray.data.origin_y; org[2] = ray.data.origin_z;
		dir[0] = ray.data.dir_x;    dir[1] = ray.data.dir_y;    dir[2] = ray.data.dir_z;
		ctx_in = '0;
		sl = $signed({{(GW-SW){1'b0}}, slack_q});
		for (int k = 0; k < 3; k++) begin
			lo = GW'(box_lo_q[k]);
			hi = GW'(box_hi_q[k]);
			dlo = GW'(eye[k]) - lo;
			dhi = GW'(eye[k]) - hi;
			alo = dlo[GW-1] ? GW'(-dlo) : dlo;
			ahi = dhi[GW-1] ? GW'(-dhi) : dhi;
			pl = (alo > ahi) ? hi : lo;
			ctx_in.in_box[k] = (eye[k] < box_hi_q[k] && eye[k] > box_lo_q[k]) ||
				(eye[k] > box_hi_q[k] && eye[k] < box_lo_q[k]);
			if (box_lo_q[k] < box_hi_q[k]) begin
				ctx_in.glo[k] = lo - sl;
				ctx_in.ghi[k] = hi + sl;
			end else begin
				ctx_in.glo[k] = lo + sl;
				ctx_in.ghi[k] = hi - sl;
			end
			diff = pl - GW'(org[k]);
			mag = diff[GW-1] ? GW'(-diff) : diff;
			ctx_in.org[k] = org[k];
			ctx_in.dir[k] = dir[k];
			ctx_in.neg[k] = diff[GW-1] ^ dir[k][CW-1];
			ctx_in.dnz[k] = (dir[k] != '0);
			div_in[k].rem = '0;
			div_in[k].quo = '0;
			div_in[k].num = {mag, {FB{1'b0}}};
			div_in[k].den = dir[k][CW-1] ? DW'(-dir[k]) : DW'(dir[k]);
		end
	end

	// Divider stages: index 0 is the front register, each further one adds a bit.
	logic [NW:0] vld_sd;
	ctx_t        ctx_sd [NW+1];
	div_t        div_sd [NW+1][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd <= '0;
		end else if (en) begin
			vld_sd <= {vld_sd[NW-1:0], ray.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_sd[0] <= ctx_in;
			for (int k = 0; k < 3; k++) begin
				div_sd[0][k] <= div_in[k];
			end
			for (int i = 0; i < NW; i++) begin
				ctx_sd[i+1] <= ctx_sd[i];
				for (int k = 0; k < 3; k++) begin
					div_sd[i+1][k] <= div_step(div_sd[i][k]);
				end
			end
		end
	end

	// Candidate flags and distances.
	logic          vld_s3;
	ctx_t          ctx_s3;
	logic [NW-1:0] t_s3 [3];
	logic [2:0]    cand_s3;
	// Partial products.
	logic          vld_s4;
	ctx_t          ctx_s4;
	logic [NW-1:0] t_s4 [3];
	logic [2:0]    cand_s4;
	logic signed [DW+QLW:0] plo_s4 [3][3];
	logic signed [DW+QHW:0] phi_s4 [3][3];
	// Full products.
	logic          vld_s5;
	ctx_t          ctx_s5;
	logic [NW-1:0] t_s5 [3];
	logic [2:0]    cand_s5;
	logic signed [PW-1:0] p_s5 [3][3];
	// Clamped hit points.
	logic          vld_s6;
	ctx_t          ctx_s6;
	logic [NW-1:0] t_s6 [3];
	logic [2:0]    cand_s6;
	logic signed [HW-1:0] h_s6 [3][3];
	// Slab checks.
	logic          vld_s7;
	logic [2:0]    inside_s7;
	coord_t        org_s7 [3];
	logic [NW-1:0] t_s7 [3];
	logic [2:0]    ok_s7;
	logic signed [HW-1:0] h_s7 [3][3];

	res_word_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_sd[NW];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			res_vld_q <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [PW-1:0] sum;
		logic signed [HW-1:0] hv, a, b;
		logic                 ok, found;
		logic [NW-1:0]        best;
		logic signed [HW-1:0] pt [3];
		if (en) begin
			ctx_s3 <= ctx_sd[NW];
			for (int k = 0; k < 3; k++) begin
				t_s3[k] <= div_sd[NW][k].quo;
				cand_s3[k] <= ctx_sd[NW].dnz[k] && !ctx_sd[NW].in_box[k] &&
					!ctx_sd[NW].neg[k] && (div_sd[NW][k].quo != '0);
			end

			ctx_s4 <= ctx_s3;
			t_s4 <= t_s3;
			cand_s4 <= cand_s3;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					plo_s4[k][j] <= $signed(ctx_s3.dir[j]) *
						$signed({1'b0, t_s3[k][QLW-1:0]});
					phi_s4[k][j] <= $signed(ctx_s3.dir[j]) *
						$signed({1'b0, t_s3[k][NW-1:QLW]});
				end
			end

			ctx_s5 <= ctx_s4;
			t_s5 <= t_s4;
			cand_s5 <= cand_s4;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					p_s5[k][j] <= (PW'(phi_s4[k][j]) <<< QLW) + PW'(plo_s4[k][j]);
				end
			end

			ctx_s6 <= ctx_s5;
			t_s6 <= t_s5;
			cand_s6 <= cand_s5;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					sum = PW'($signed(ctx_s5.org[j])) + (p_s5[k][j] >>> FB);
					if (sum > HMAX) begin
						h_s6[k][j] <= HMAX[HW-1:0];
					end else if (sum < HMIN) begin
						h_s6[k][j] <= HMIN[HW-1:0];
					end else begin
						h_s6[k][j] <= sum[HW-1:0];
					end
				end
			end

			inside_s7 <= ctx_s6.in_box;
			for (int k = 0; k < 3; k++) begin
				org_s7[k] <= ctx_s6.org[k];
			end
			t_s7 <= t_s6;
			h_s7 <= h_s6;
			for (int k = 0; k < 3; k++) begin
				ok = cand_s6[k];
				for (int j = 0; j < 3; j++) begin
					hv = h_s6[k][j];
					a = HW'($signed(ctx_s6.glo[j]));
					b = HW'($signed(ctx_s6.ghi[j]));
					if (j != k && !((hv >= a && hv <= b) || (hv <= a && hv >= b))) begin
						ok = 1'b0;
					end
				end
				ok_s7[k] <= ok;
			end

			found = 1'b0;
			best = '0;
			for (int j = 0; j < 3; j++) begin
				pt[j] = '0;
			end
			if (&inside_s7) begin
				found = 1'b1;
				for (int j = 0; j < 3; j++) begin
					pt[j] = HW'(org_s7[j]);
				end
			end else begin
				for (int k = 0; k < 3; k++) begin
					if (ok_s7[k] && (!found || t_s7[k] > best)) begin
						found = 1'b1;
						best = t_s7[k];
						for (int j = 0; j < 3; j++) begin
							pt[j] = h_s7[k][j];
						end
					end
				end
			end
			for (int j = 0; j < 3; j++) begin
				if (pt[j] > CMAX) begin
					pt[j] = CMAX;
				end else if (pt[j] < CMIN) begin
					pt[j] = CMIN;
				end
			end
			res_q.hit <= found;
			res_q.hit_x <= pt[0][CW-1:0];
			res_q.hit_y <= pt[1][CW-1:0];
			res_q.hit_z <= pt[2][CW-1:0];
		end
	end

	assign res.valid = res_vld_q;
	assign res.data = res_q;

endmodule

@@ rtl/rbi_checker.sv @@
// ----------------------------------------------------------------------------
// Ray box core checker
// Port-level checks on the handshakes and the result word.
// ----------------------------------------------------------------------------
`include "ray_box_intersect_core_macros.svh"

module rbi_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                ray_ready,
	input logic                res_valid,
	input logic                res_ready,
	input logic                res_hit,
	input logic [rbi_pkg::CW-1:0] res_hit_x,
	input logic [rbi_pkg::CW-1:0] res_hit_y,
	input logic [rbi_pkg::CW-1:0] res_hit_z
);
	import rbi_pkg::*;

	`RBI_ASSERT(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid, "result word dropped while stalled")
	`RBI_ASSERT(a_stall_blocks, clk, arst_n, res_valid && !res_ready |-> !ray_ready, "ray taken while the pipeline is stalled")
	`RBI_ASSERT(a_miss_zero, clk, arst_n, res_valid && !res_hit |-> res_hit_x == '0 && res_hit_y == '0 && res_hit_z == '0, "miss carries a non-zero point")
	`RBI_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !res_valid, "result valid during reset")

endmodule

bind ray_box_intersect_core rbi_checker u_rbi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.ray_ready (ray.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_hit   (res.data.hit),
	.res_hit_x (res.data.hit_x),
	.res_hit_y (res.data.hit_y),
	.res_hit_z (res.data.hit_z)
);
